>>> sv/v2d_pkg.sv
// Package with the item types, action codes and pipeline constants of the vector unit.
package v2d_pkg;
    localparam int FRAC_BITS = 8;
    localparam int SQ_W      = 32;               // ax^2 + ay^2 reaches 2^31
    localparam int ROOT_STEPS = 16;              // one result bit per root cell
    localparam int NUM_W     = 16 + FRAC_BITS;   // dividend width of normalize
    localparam int QUO_W     = NUM_W;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_SUB    = 3'd1,
        ACT_SCALE  = 3'd2,
        ACT_LENGTH = 3'd3,
        ACT_NORM   = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] scale_factor;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] result_x;
        logic signed [15:0] result_y;
        logic [15:0]        magnitude;
        logic               saturated;
    } t_out_item;

    // Per-item context handed along the chain.
    typedef struct packed {
        logic               vld;
        logic [2:0]         action;
        logic               neg_x;
        logic               neg_y;
        logic [15:0]        mag_x;
        logic [15:0]        mag_y;
        logic signed [17:0] lin_x;   // add/sub/scale result, held at most one past 16 bits
        logic signed [17:0] lin_y;
    } t_ctx;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [15:0]     root;
    } t_root_st;

    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [16:0]      rem_x;
        logic [16:0]      rem_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } t_div_st;

    function automatic logic signed [15:0] clip16(input logic signed [QUO_W+1:0] v,
                                                  output logic sat);
        sat = 1'b0;
        clip16 = v[15:0];
        if (v > 32767) begin
            sat = 1'b1;
            clip16 = 16'sh7fff;
        end else if (v < -32768) begin
            sat = 1'b1;
            clip16 = -16'sh8000;
        end
    endfunction
endpackage

>>> sv/v2d_root_cell.sv
// One cell of the square root chain: decides one root bit per item.
module v2d_root_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [4:0]          i_step,
    input  v2d_pkg::t_ctx       i_ctx,
    input  v2d_pkg::t_root_st   i_st,
    output v2d_pkg::t_ctx       o_ctx,
    output v2d_pkg::t_root_st   o_st
);
    import v2d_pkg::*;

    t_root_st n_st;
    logic [SQ_W+1:0] trial;
    logic [SQ_W+1:0] bitv;
    logic [SQ_W+1:0] ext_rem;

    always_comb begin
        // Bit weight 4^(15-step) against the partially built root.
        bitv    = '0;
        bitv[2*(15-i_step)] = 1'b1;
        ext_rem = {2'b00, i_st.rem};
        trial   = ({{(SQ_W-14){1'b0}}, i_st.root} << (5'd16 - i_step)) + bitv;
        n_st    = i_st;
        if (ext_rem >= trial) begin
            n_st.rem  = SQ_W'(ext_rem - trial);
            n_st.root = i_st.root | (16'd1 << (5'd15 - i_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctx.vld <= 1'b0;
        end else if (i_en) begin
            o_ctx.vld <= i_ctx.vld;
        end
        if (i_en) begin
            o_ctx.action    <= i_ctx.action;
            o_ctx.neg_x     <= i_ctx.neg_x;
            o_ctx.neg_y     <= i_ctx.neg_y;
            o_ctx.mag_x     <= i_ctx.mag_x;
            o_ctx.mag_y     <= i_ctx.mag_y;
            o_ctx.lin_x     <= i_ctx.lin_x;
            o_ctx.lin_y     <= i_ctx.lin_y;
            o_st            <= n_st;
        end
    end
endmodule

>>> sv/v2d_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for x and for y.
module v2d_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  v2d_pkg::t_ctx     i_ctx,
    input  logic [15:0]       i_len,
    input  v2d_pkg::t_div_st  i_st,
    output v2d_pkg::t_ctx     o_ctx,
    output logic [15:0]       o_len,
    output v2d_pkg::t_div_st  o_st
);
    import v2d_pkg::*;

    t_div_st n_st;
    logic [17:0] px;
    logic [17:0] py;

    always_comb begin
        n_st = i_st;
        px = {i_st.rem_x, i_st.num_x[NUM_W-1]};
        py = {i_st.rem_y, i_st.num_y[NUM_W-1]};
        n_st.num_x = i_st.num_x << 1;
        n_st.num_y = i_st.num_y << 1;
        if (px >= {2'b00, i_len}) begin
            n_st.rem_x = 17'(px - {2'b00, i_len});
            n_st.quo_x = {i_st.quo_x[QUO_W-2:0], 1'b1};
        end else begin
            n_st.rem_x = px[16:0];
            n_st.quo_x = {i_st.quo_x[QUO_W-2:0], 1'b0};
        end
        if (py >= {2'b00, i_len}) begin
            n_st.rem_y = 17'(py - {2'b00, i_len});
            n_st.quo_y = {i_st.quo_y[QUO_W-2:0], 1'b1};
        end else begin
            n_st.rem_y = py[16:0];
            n_st.quo_y = {i_st.quo_y[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctx.vld <= 1'b0;
        end else if (i_en) begin
            o_ctx.vld <= i_ctx.vld;
        end
        if (i_en) begin
            o_ctx.action    <= i_ctx.action;
            o_ctx.neg_x     <= i_ctx.neg_x;
            o_ctx.neg_y     <= i_ctx.neg_y;
            o_ctx.mag_x     <= i_ctx.mag_x;
            o_ctx.mag_y     <= i_ctx.mag_y;
            o_ctx.lin_x     <= i_ctx.lin_x;
            o_ctx.lin_y     <= i_ctx.lin_y;
            o_len           <= i_len;
            o_st            <= n_st;
        end
    end
endmodule

>>> sv/vector2d_alu.sv
// Top level of the 2-D vector unit: front stage, root chain, divider chain, output.
//
// Each item is one stage deep per cell: two front stages (products, then sum of
// squares), sixteen root cells that each settle one bit of the length, 16+FRAC_BITS
// divider cells that each settle one quotient bit of the normalize result, and an
// output register (FRAC_BITS = 8 at Q8.8). One item is accepted every cycle while
// the output is not stalled. The whole chain advances together; o_out_valid held
// with i_out_stall high freezes it and raises o_in_stall.
module vector2d_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  v2d_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output v2d_pkg::t_out_item  o_out_data
);
    import v2d_pkg::*;

    logic en;
    assign en = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Front stage 1: products and linear results.
    t_ctx              r_c1;
    logic [31:0]       r_sqx, r_sqy;
    t_ctx              n_c1;
    logic signed [31:0] px, py;

    always_comb begin
        n_c1.vld    = i_in_valid;
        n_c1.action = i_in_data.action;
        n_c1.neg_x  = i_in_data.first_x[15];
        n_c1.neg_y  = i_in_data.first_y[15];
        n_c1.mag_x  = i_in_data.first_x[15] ? 16'(-i_in_data.first_x) : i_in_data.first_x;
        n_c1.mag_y  = i_in_data.first_y[15] ? 16'(-i_in_data.first_y) : i_in_data.first_y;
        px = i_in_data.first_x * i_in_data.scale_factor;
        py = i_in_data.first_y * i_in_data.scale_factor;
        n_c1.lin_x = '0;
        n_c1.lin_y = '0;
        unique case (i_in_data.action)
            ACT_ADD: begin
                n_c1.lin_x = 18'(i_in_data.first_x) + 18'(i_in_data.second_x);
                n_c1.lin_y = 18'(i_in_data.first_y) + 18'(i_in_data.second_y);
            end
            ACT_SUB: begin
                n_c1.lin_x = 18'(i_in_data.second_x) - 18'(i_in_data.first_x);
                n_c1.lin_y = 18'(i_in_data.second_y) - 18'(i_in_data.first_y);
            end
            ACT_SCALE: begin
                // Truncate toward zero: add 2^F-1 to negative products before shifting.
                logic signed [32:0] tx, ty;
                tx = (33'(px) + 33'(px < 0 ? (1 << FRAC_BITS) - 1 : 0)) >>> FRAC_BITS;
                ty = (33'(py) + 33'(py < 0 ? (1 << FRAC_BITS) - 1 : 0)) >>> FRAC_BITS;
                // Values far out of range are held just past it so the output clips them.
                n_c1.lin_x = (tx > 32767) ? 18'sd32768 :
                             (tx < -32768) ? -18'sd32769 : tx[17:0];
                n_c1.lin_y = (ty > 32767) ? 18'sd32768 :
                             (ty < -32768) ? -18'sd32769 : ty[17:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.vld <= 1'b0;
        end else if (en) begin
            r_c1.vld <= n_c1.vld;
        end
        if (en) begin
            r_c1[$bits(t_ctx)-2:0] <= n_c1[$bits(t_ctx)-2:0];
            r_sqx <= 32'(n_c1.mag_x) * 32'(n_c1.mag_x);
            r_sqy <= 32'(n_c1.mag_y) * 32'(n_c1.mag_y);
        end
    end

    // Front stage 2: sum of squares.
    t_ctx     root_ctx [0:ROOT_STEPS];
    t_root_st root_st  [0:ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_ctx[0].vld <= 1'b0;
        end else if (en) begin
            root_ctx[0].vld <= r_c1.vld;
        end
        if (en) begin
            root_ctx[0][$bits(t_ctx)-2:0] <= r_c1[$bits(t_ctx)-2:0];
            root_st[0].rem  <= SQ_W'(r_sqx + r_sqy);
            root_st[0].root <= '0;
        end
    end

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        v2d_root_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_step (5'(g)),
            .i_ctx  (root_ctx[g]),
            .i_st   (root_st[g]),
            .o_ctx  (root_ctx[g+1]),
            .o_st   (root_st[g+1])
        );
    end

    t_ctx        div_ctx [0:QUO_W];
    t_div_st     div_st  [0:QUO_W];
    logic [15:0] div_len [0:QUO_W];

    assign div_ctx[0]        = root_ctx[ROOT_STEPS];
    assign div_len[0]        = root_st[ROOT_STEPS].root;
    assign div_st[0].num_x   = {root_ctx[ROOT_STEPS].mag_x, {FRAC_BITS{1'b0}}};
    assign div_st[0].num_y   = {root_ctx[ROOT_STEPS].mag_y, {FRAC_BITS{1'b0}}};
    assign div_st[0].rem_x   = '0;
    assign div_st[0].rem_y   = '0;
    assign div_st[0].quo_x   = '0;
    assign div_st[0].quo_y   = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        v2d_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctx  (div_ctx[g]),
            .i_len  (div_len[g]),
            .i_st   (div_st[g]),
            .o_ctx  (div_ctx[g+1]),
            .o_len  (div_len[g+1]),
            .o_st   (div_st[g+1])
        );
    end

    // Output stage: select, sign and clip.
    t_ctx      fc;
    t_out_item n_out;
    t_out_item r_out;
    logic      r_vld;
    logic      sx, sy;
    logic signed [QUO_W+1:0] vx, vy;

    assign fc = div_ctx[QUO_W];

    always_comb begin
        n_out.magnitude = div_len[QUO_W];
        vx = '0;
        vy = '0;
        unique case (fc.action)
            ACT_ADD, ACT_SUB, ACT_SCALE: begin
                vx = (QUO_W+2)'(fc.lin_x);
                vy = (QUO_W+2)'(fc.lin_y);
            end
            ACT_NORM: begin
                if (div_len[QUO_W] != '0) begin
                    vx = (QUO_W+2)'(div_st[QUO_W].quo_x);
                    vy = (QUO_W+2)'(div_st[QUO_W].quo_y);
                    if (fc.neg_x) vx = -vx;
                    if (fc.neg_y) vy = -vy;
                end
            end
            default: ;
        endcase
        n_out.result_x  = clip16(vx, sx);
        n_out.result_y  = clip16(vy, sy);
        n_out.saturated = sx | sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= fc.vld;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while the output item is held");
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.magnitude <= 16'd46341))
        else $error("length out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |-> $stable(o_out_data))
        else $error("stalled output item changed");
`endif
endmodule
